// ----- design/xss_pkg.sv -----
// ----------------------------------------------------------------------------
// xss_pkg
// Shared constants, codes and control types for the xoshiro256** generator.
// ----------------------------------------------------------------------------
package xss_pkg;

    // default sizes
    localparam int XSS_MAX_WORDS     = 64;
    localparam int XSS_WARMUP_ROUNDS = 8;

    // warm-up counter width covers the whole 0..15 range of rounds
    localparam int XSS_WARM_W = 4;

    // field widths
    localparam int XSS_WORD_W  = 64;
    localparam int XSS_COUNT_W = 10;
    localparam int XSS_TAKE_W  = 4;
    localparam int XSS_ADDR_W  = 2;

    // seed register reset values
    localparam logic [XSS_WORD_W-1:0] XSS_SEED0_RST = 64'd1;
    localparam logic [XSS_WORD_W-1:0] XSS_SEED1_RST = 64'd2;
    localparam logic [XSS_WORD_W-1:0] XSS_SEED2_RST = 64'd3;
    localparam logic [XSS_WORD_W-1:0] XSS_SEED3_RST = 64'd4;

    // request codes
    localparam logic REQ_RESEED = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    // configuration register indexes
    localparam logic [XSS_ADDR_W-1:0] CFG_SEED0 = 2'd0;
    localparam logic [XSS_ADDR_W-1:0] CFG_SEED1 = 2'd1;
    localparam logic [XSS_ADDR_W-1:0] CFG_SEED2 = 2'd2;
    localparam logic [XSS_ADDR_W-1:0] CFG_SEED3 = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load_seed;
        logic warm_step;
        logic load_fill;
        logic gen_step;
        logic finish;
    } t_xss_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic last;
        logic out_free;
    } t_xss_status;

endpackage

// ----- design/xss_dp.sv -----
// ----------------------------------------------------------------------------
// xss_dp
// Datapath: seed registers, generator state, byte counter, output register.
// ----------------------------------------------------------------------------
module xss_dp
    import xss_pkg::*;
#(
    parameter int MAX_WORDS = XSS_MAX_WORDS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [XSS_ADDR_W-1:0]   i_cfg_addr,
    input  logic [XSS_WORD_W-1:0]   i_cfg_data,
    input  logic [XSS_COUNT_W-1:0]  i_byte_count,
    input  logic                    i_out_stall,
    input  t_xss_cmd                i_cmd,
    output t_xss_status             o_status,
    output logic                    o_out_valid,
    output logic [XSS_WORD_W-1:0]   o_random_word,
    output logic [XSS_TAKE_W-1:0]   o_valid_bytes,
    output logic                    o_last_word
);

    localparam int MAX_BYTES = MAX_WORDS * 8;
    localparam int BL_W      = $clog2(MAX_BYTES + 1);

    logic [XSS_WORD_W-1:0] r_seed [4];
    logic [XSS_WORD_W-1:0] r_s    [4];
    logic [XSS_WORD_W-1:0] n_s    [4];
    logic [XSS_WORD_W-1:0] r_prod;
    logic [XSS_WORD_W-1:0] n_prod;
    logic [BL_W-1:0]       r_bytes_left;
    logic [BL_W-1:0]       n_count;
    logic [XSS_TAKE_W-1:0] n_take;
    logic [XSS_WORD_W-1:0] n_word;
    logic [XSS_WORD_W-1:0] n_mul5;
    logic                  r_out_valid;
    logic [XSS_WORD_W-1:0] r_out_word;
    logic [XSS_TAKE_W-1:0] r_out_take;
    logic                  r_out_last;

    // low-byte mask for a partial final word
    function automatic logic [XSS_WORD_W-1:0] byte_mask(input logic [XSS_TAKE_W-1:0] take);
        logic [XSS_WORD_W-1:0] m;
        m = '1;
        case (take)
            4'd1:    m = 64'h0000_0000_0000_00FF;
            4'd2:    m = 64'h0000_0000_0000_FFFF;
            4'd3:    m = 64'h0000_0000_00FF_FFFF;
            4'd4:    m = 64'h0000_0000_FFFF_FFFF;
            4'd5:    m = 64'h0000_00FF_FFFF_FFFF;
            4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
            4'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    // one generator step of the state words
    always_comb begin
        logic [XSS_WORD_W-1:0] t2;
        logic [XSS_WORD_W-1:0] t3;
        t2      = r_s[2] ^ r_s[0];
        t3      = r_s[3] ^ r_s[1];
        n_s[1]  = r_s[1] ^ t2;
        n_s[0]  = r_s[0] ^ t3;
        n_s[2]  = t2 ^ (r_s[1] << 17);
        n_s[3]  = {t3[XSS_WORD_W-46:0], t3[XSS_WORD_W-1:XSS_WORD_W-45]};
    end

    // scrambler: first half (times 5, rotate 7), second half (times 9)
    assign n_mul5 = r_s[1] + (r_s[1] << 2);
    assign n_prod = {n_mul5[XSS_WORD_W-8:0], n_mul5[XSS_WORD_W-1:XSS_WORD_W-7]};

    // saturated request size and bytes in the current word
    assign n_count = (i_byte_count > XSS_COUNT_W'(MAX_BYTES)) ? BL_W'(MAX_BYTES)
                                                              : i_byte_count[BL_W-1:0];
    assign n_take  = (r_bytes_left >= BL_W'(8)) ? XSS_TAKE_W'(8)
                                                : {1'b0, r_bytes_left[2:0]};
    assign n_word  = (r_prod + (r_prod << 3)) & byte_mask(n_take);

    // seed registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed[0] <= XSS_SEED0_RST;
            r_seed[1] <= XSS_SEED1_RST;
            r_seed[2] <= XSS_SEED2_RST;
            r_seed[3] <= XSS_SEED3_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SEED0: r_seed[0] <= i_cfg_data;
                CFG_SEED1: r_seed[1] <= i_cfg_data;
                CFG_SEED2: r_seed[2] <= i_cfg_data;
                CFG_SEED3: r_seed[3] <= i_cfg_data;
                default:   r_seed[0] <= r_seed[0];
            endcase
        end
    end

    // generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s[0] <= XSS_SEED0_RST;
            r_s[1] <= XSS_SEED1_RST;
            r_s[2] <= XSS_SEED2_RST;
            r_s[3] <= XSS_SEED3_RST;
        end else if (i_cmd.load_seed) begin
            r_s <= r_seed;
        end else if (i_cmd.warm_step || i_cmd.gen_step) begin
            r_s <= n_s;
        end
    end

    // scrambler stage register
    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_step) begin
            r_prod <= n_prod;
        end
    end

    // bytes still owed by the fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
        end else if (i_cmd.load_fill) begin
            r_bytes_left <= n_count;
        end else if (i_cmd.finish) begin
            r_bytes_left <= r_bytes_left - BL_W'(n_take);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_word <= n_word;
            r_out_take <= n_take;
            r_out_last <= (r_bytes_left <= BL_W'(8));
        end
    end

    // status to controller
    assign o_status.count_zero = (i_byte_count == '0);
    assign o_status.last       = (r_bytes_left <= BL_W'(8));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;
    assign o_valid_bytes = r_out_take;
    assign o_last_word   = r_out_last;

endmodule

// ----- design/xss_ctrl.sv -----
// ----------------------------------------------------------------------------
// xss_ctrl
// Controller: accepts requests, sequences warm-up and word generation.
// ----------------------------------------------------------------------------
module xss_ctrl
    import xss_pkg::*;
#(
    parameter int WARMUP_ROUNDS = XSS_WARMUP_ROUNDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_req_type,
    input  t_xss_status i_status,
    output logic        o_in_stall,
    output t_xss_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WARM,
        S_GEN,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [XSS_WARM_W-1:0] r_warm_left;
    logic                  in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_seed = in_acc && (i_req_type == REQ_RESEED);
        o_cmd.load_fill = in_acc && (i_req_type == REQ_FILL) && !i_status.count_zero;
        o_cmd.warm_step = (r_state == S_WARM);
        o_cmd.gen_step  = (r_state == S_GEN);
        o_cmd.finish    = (r_state == S_FIN) && i_status.out_free;
    end

    // state and warm-up counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_warm_left <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load_seed && (WARMUP_ROUNDS != 0)) begin
                        r_state     <= S_WARM;
                        r_warm_left <= XSS_WARM_W'(WARMUP_ROUNDS);
                    end else if (o_cmd.load_fill) begin
                        r_state <= S_GEN;
                    end
                end
                S_WARM: begin
                    r_warm_left <= r_warm_left - XSS_WARM_W'(1);
                    if (r_warm_left <= XSS_WARM_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_GEN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_status.out_free) begin
                        r_state <= i_status.last ? S_IDLE : S_GEN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/xoshiro256_starstar_generator.sv -----
// ----------------------------------------------------------------------------
// xoshiro256_starstar_generator
// xoshiro256** random word source with reseed and byte-count fill requests.
// ----------------------------------------------------------------------------
// A reseed transaction (req_type 0) copies the four seed registers into the
// generator state and then runs WARMUP_ROUNDS discarded steps, one per cycle,
// stalling the input until the last one. A fill transaction (req_type 1)
// returns ceil(byte_count/8) words, capped at MAX_WORDS; each word gets a
// state step and the times-5 scrambler half in S_GEN, then the times-9 half in
// S_FIN, where an output stall holds it; the input stays stalled until the
// last word is registered. A fill of zero bytes produces nothing. Bytes beyond
// valid_bytes in the final word read as zero. The user must write the seed
// registers through the cfg port while idle; the block does not enforce this.
module xoshiro256_starstar_generator
    import xss_pkg::*;
#(
    parameter int MAX_WORDS     = XSS_MAX_WORDS,
    parameter int WARMUP_ROUNDS = XSS_WARMUP_ROUNDS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [XSS_ADDR_W-1:0]  i_cfg_addr,
    input  logic [XSS_WORD_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_req_type,
    input  logic [XSS_COUNT_W-1:0] i_byte_count,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [XSS_WORD_W-1:0]  o_random_word,
    output logic [XSS_TAKE_W-1:0]  o_valid_bytes,
    output logic                   o_last_word
);

    t_xss_cmd    cmd;
    t_xss_status status;

    // sequencing
    xss_ctrl #(
        .WARMUP_ROUNDS (WARMUP_ROUNDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // generator state and output
    xss_dp #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_byte_count  (i_byte_count),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_random_word (o_random_word),
        .o_valid_bytes (o_valid_bytes),
        .o_last_word   (o_last_word)
    );

endmodule
